>>> rtl/sorted_priority_queue_remove_by_id_top_defines.svh
// Assertion macros for the sorted priority queue.
// Included by the top level; depends on nothing else.
`ifndef SORTED_PRIORITY_QUEUE_REMOVE_BY_ID_TOP_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_REMOVE_BY_ID_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/spq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sorted priority queue.
// Used by spq_cell, spq_ctrl and the top level; no dependencies.
package spq_pkg;

	localparam int DEPTH_DEF        = 128;
	localparam int PAYLOAD_BITS_DEF = 16;
	localparam int ID_W             = 8;
	localparam int PRI_W            = 8;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_EMPTY     = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_SCAN
	} fsm_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     wrap;
	} chain_ctl_t;

endpackage

>>> rtl/sorted_priority_queue_remove_by_id_top.sv
`timescale 1ns / 1ps
// Sorted priority queue with removal by id: top level, a row of spq_cell
// under spq_ctrl. Depends on spq_pkg and the assertion macro header.
//
// Request channel (req_valid / req_stall) carries command, entry_id,
// entry_priority and entry_payload; a transfer happens when req_valid is
// high and req_stall low. Every request gives one response on the
// rsp_valid / rsp_stall channel: status, the removed entry (zero unless an
// ok remove) and the occupancy after the operation.
// Insert, full and empty cases: response in the cycle after the transfer, one
// request per cycle. An insert compares its priority in every cell at once
// and shifts the tail side of the row by one slot.
// Remove: every stored entry rotates through the head cell, one entry per
// cycle, and the response follows the last step; the first matching entry is
// pulled out at the head and the rest return to their order. No request is
// taken during that rotation.
// A response waits in its output register while rsp_stall is high; no new
// request is taken in that time, but one is taken in the cycle in which the
// register is being drained.
// Reset empties the queue (count zero, no response pending); cell contents
// are not cleared and are never read until written.
`include "sorted_priority_queue_remove_by_id_top_defines.svh"
module sorted_priority_queue_remove_by_id_top #(
	parameter int DEPTH        = spq_pkg::DEPTH_DEF,
	parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic                          command,
	input  logic [spq_pkg::ID_W-1:0]      entry_id,
	input  logic [spq_pkg::PRI_W-1:0]     entry_priority,
	input  logic [PAYLOAD_BITS-1:0]       entry_payload,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [1:0]                    status,
	output logic [spq_pkg::ID_W-1:0]      removed_id,
	output logic [spq_pkg::PRI_W-1:0]     removed_priority,
	output logic [PAYLOAD_BITS-1:0]       removed_payload,
	output logic [$clog2(DEPTH+1)-1:0]    occupancy
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	spq_pkg::chain_ctl_t       ctl;
	logic [CNT_W-1:0]          count;
	logic [CNT_W-1:0]          tail;
	logic [spq_pkg::ID_W-1:0]  cell_id  [DEPTH];
	logic [spq_pkg::PRI_W-1:0] cell_pri [DEPTH];
	logic [PAYLOAD_BITS-1:0]   cell_pay [DEPTH];
	logic                      cell_ins [DEPTH];

	spq_ctrl #(
		.DEPTH        (DEPTH),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.req_valid        (req_valid),
		.req_stall        (req_stall),
		.command          (command),
		.entry_id         (entry_id),
		.head_id          (cell_id[0]),
		.head_pri         (cell_pri[0]),
		.head_pay         (cell_pay[0]),
		.ctl              (ctl),
		.count            (count),
		.tail             (tail),
		.rsp_valid        (rsp_valid),
		.rsp_stall        (rsp_stall),
		.status           (status),
		.removed_id       (removed_id),
		.removed_priority (removed_priority),
		.removed_payload  (removed_payload),
		.occupancy        (occupancy)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                      ins_left;
		logic [spq_pkg::ID_W-1:0]  left_id, right_id;
		logic [spq_pkg::PRI_W-1:0] left_pri, right_pri;
		logic [PAYLOAD_BITS-1:0]   left_pay, right_pay;

		if (i == 0) begin : g_first
			assign ins_left = 1'b0;
			assign left_id  = entry_id;
			assign left_pri = entry_priority;
			assign left_pay = entry_payload;
		end else begin : g_mid
			assign ins_left = cell_ins[i-1];
			assign left_id  = cell_id[i-1];
			assign left_pri = cell_pri[i-1];
			assign left_pay = cell_pay[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_id  = cell_id[0];
			assign right_pri = cell_pri[0];
			assign right_pay = cell_pay[0];
		end else begin : g_inner
			assign right_id  = cell_id[i+1];
			assign right_pri = cell_pri[i+1];
			assign right_pay = cell_pay[i+1];
		end

		spq_cell #(
			.DEPTH        (DEPTH),
			.PAYLOAD_BITS (PAYLOAD_BITS),
			.IDX          (i)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.count     (count),
			.tail      (tail),
			.new_id    (entry_id),
			.new_pri   (entry_priority),
			.new_pay   (entry_payload),
			.ins_left  (ins_left),
			.left_id   (left_id),
			.left_pri  (left_pri),
			.left_pay  (left_pay),
			.right_id  (right_id),
			.right_pri (right_pri),
			.right_pay (right_pay),
			.head_id   (cell_id[0]),
			.head_pri  (cell_pri[0]),
			.head_pay  (cell_pay[0]),
			.ins_here  (cell_ins[i]),
			.id        (cell_id[i]),
			.pri       (cell_pri[i]),
			.pay       (cell_pay[i])
		);
	end

	`SPQ_ASSERT_NOW(a_insert_on_transfer, clk, arst_n, ctl.op == spq_pkg::CELL_INSERT, req_valid && !req_stall && command == spq_pkg::CMD_INSERT, "insert shift without a request transfer")
	`SPQ_ASSERT_NEXT(a_insert_count, clk, arst_n, ctl.op == spq_pkg::CELL_INSERT, count == CNT_W'($past(count) + 1'b1), "count did not advance after insert")
	`SPQ_ASSERT_NOW(a_full_occupancy, clk, arst_n, rsp_valid && status == spq_pkg::STAT_FULL, occupancy == CNT_W'(DEPTH), "full status with queue not full")
	`SPQ_ASSERT_NOW(a_empty_occupancy, clk, arst_n, rsp_valid && status == spq_pkg::STAT_EMPTY, occupancy == '0, "empty status with entries stored")

endmodule

>>> rtl/spq_cell.sv
`timescale 1ns / 1ps
// One storage cell of the sorted chain: holds id, priority and payload.
// Depends on spq_pkg for the chain control struct.
module spq_cell #(
	parameter int DEPTH        = spq_pkg::DEPTH_DEF,
	parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF,
	parameter int IDX          = 0
) (
	input  logic                          clk,
	input  spq_pkg::chain_ctl_t           ctl,
	input  logic [$clog2(DEPTH+1)-1:0]    count,
	input  logic [$clog2(DEPTH+1)-1:0]    tail,
	input  logic [spq_pkg::ID_W-1:0]      new_id,
	input  logic [spq_pkg::PRI_W-1:0]     new_pri,
	input  logic [PAYLOAD_BITS-1:0]       new_pay,
	input  logic                          ins_left,
	input  logic [spq_pkg::ID_W-1:0]      left_id,
	input  logic [spq_pkg::PRI_W-1:0]     left_pri,
	input  logic [PAYLOAD_BITS-1:0]       left_pay,
	input  logic [spq_pkg::ID_W-1:0]      right_id,
	input  logic [spq_pkg::PRI_W-1:0]     right_pri,
	input  logic [PAYLOAD_BITS-1:0]       right_pay,
	input  logic [spq_pkg::ID_W-1:0]      head_id,
	input  logic [spq_pkg::PRI_W-1:0]     head_pri,
	input  logic [PAYLOAD_BITS-1:0]       head_pay,
	output logic                          ins_here,
	output logic [spq_pkg::ID_W-1:0]      id,
	output logic [spq_pkg::PRI_W-1:0]     pri,
	output logic [PAYLOAD_BITS-1:0]       pay
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [spq_pkg::ID_W-1:0]  id_q;
	logic [spq_pkg::PRI_W-1:0] pri_q;
	logic [PAYLOAD_BITS-1:0]   pay_q;
	logic                      wrap_here;

	// New entry belongs at or before this cell: empty slot or lower priority here.
	assign ins_here  = (CNT_W'(IDX) >= count) || (pri_q < new_pri);
	assign wrap_here = ctl.wrap && (CNT_W'(IDX) == tail);

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			spq_pkg::CELL_INSERT: begin
				if (ins_left) begin
					id_q  <= left_id;
					pri_q <= left_pri;
					pay_q <= left_pay;
				end else if (ins_here) begin
					id_q  <= new_id;
					pri_q <= new_pri;
					pay_q <= new_pay;
				end
			end
			spq_pkg::CELL_ROTATE: begin
				// advance toward the head; the tail slot takes the head back on a wrap
				if (wrap_here) begin
					id_q  <= head_id;
					pri_q <= head_pri;
					pay_q <= head_pay;
				end else begin
					id_q  <= right_id;
					pri_q <= right_pri;
					pay_q <= right_pay;
				end
			end
			default: begin
			end
		endcase
	end

	assign id  = id_q;
	assign pri = pri_q;
	assign pay = pay_q;

endmodule

>>> rtl/spq_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the sorted chain: handshakes, entry count, remove scan
// and the result register. Depends on spq_pkg.
module spq_ctrl #(
	parameter int DEPTH        = spq_pkg::DEPTH_DEF,
	parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic                          command,
	input  logic [spq_pkg::ID_W-1:0]      entry_id,
	input  logic [spq_pkg::ID_W-1:0]      head_id,
	input  logic [spq_pkg::PRI_W-1:0]     head_pri,
	input  logic [PAYLOAD_BITS-1:0]       head_pay,
	output spq_pkg::chain_ctl_t           ctl,
	output logic [$clog2(DEPTH+1)-1:0]    count,
	output logic [$clog2(DEPTH+1)-1:0]    tail,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [1:0]                    status,
	output logic [spq_pkg::ID_W-1:0]      removed_id,
	output logic [spq_pkg::PRI_W-1:0]     removed_priority,
	output logic [PAYLOAD_BITS-1:0]       removed_payload,
	output logic [$clog2(DEPTH+1)-1:0]    occupancy
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	spq_pkg::fsm_t             state_q, state_d;
	logic [CNT_W-1:0]          count_q, count_d;
	logic [CNT_W-1:0]          steps_q, len_q;
	logic                      found_q;
	logic [spq_pkg::ID_W-1:0]  id_q;
	logic                      rsp_valid_q;
	spq_pkg::status_t          status_q, res_status;
	logic [CNT_W-1:0]          occ_q, res_occ;
	logic [spq_pkg::ID_W-1:0]  rem_id_q;
	logic [spq_pkg::PRI_W-1:0] rem_pri_q;
	logic [PAYLOAD_BITS-1:0]   rem_pay_q;
	logic                      accept, full, hit, last_step;
	logic                      start_scan, load_res, clr_rem;
	logic [CNT_W-1:0]          len_next;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign hit       = (state_q == spq_pkg::FSM_SCAN) && !found_q && (head_id == id_q);
	assign last_step = (steps_q == CNT_W'(1));
	assign len_next  = hit ? CNT_W'(len_q - 1'b1) : len_q;
	assign accept    = req_valid && !req_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			spq_pkg::FSM_IDLE: begin
				if (accept && command == spq_pkg::CMD_REMOVE && count_q != '0) begin
					state_d = spq_pkg::FSM_SCAN;
				end
			end
			spq_pkg::FSM_SCAN: begin
				if (last_step) begin
					state_d = spq_pkg::FSM_IDLE;
				end
			end
			default: state_d = spq_pkg::FSM_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_stall  = 1'b1;
		ctl.op     = spq_pkg::CELL_HOLD;
		ctl.wrap   = 1'b0;
		start_scan = 1'b0;
		load_res   = 1'b0;
		clr_rem    = 1'b0;
		res_status = spq_pkg::STAT_OK;
		res_occ    = count_q;
		count_d    = count_q;
		unique case (state_q)
			spq_pkg::FSM_IDLE: begin
				req_stall = rsp_valid_q && rsp_stall;
				if (accept) begin
					clr_rem = 1'b1;
					if (command == spq_pkg::CMD_INSERT) begin
						load_res = 1'b1;
						if (full) begin
							res_status = spq_pkg::STAT_FULL;
						end else begin
							ctl.op  = spq_pkg::CELL_INSERT;
							count_d = CNT_W'(count_q + 1'b1);
							res_occ = count_d;
						end
					end else if (count_q == '0) begin
						load_res   = 1'b1;
						res_status = spq_pkg::STAT_EMPTY;
					end else begin
						start_scan = 1'b1;
					end
				end
			end
			spq_pkg::FSM_SCAN: begin
				ctl.op   = spq_pkg::CELL_ROTATE;
				ctl.wrap = !hit;
				if (last_step) begin
					load_res   = 1'b1;
					res_status = (found_q || hit) ? spq_pkg::STAT_OK : spq_pkg::STAT_NOT_FOUND;
					res_occ    = len_next;
					count_d    = len_next;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= spq_pkg::FSM_IDLE;
			count_q     <= '0;
			steps_q     <= '0;
			len_q       <= '0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (start_scan) begin
				steps_q <= count_q;
				len_q   <= count_q;
				found_q <= 1'b0;
			end else if (state_q == spq_pkg::FSM_SCAN) begin
				steps_q <= CNT_W'(steps_q - 1'b1);
				len_q   <= len_next;
				found_q <= found_q || hit;
			end
			if (load_res) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_scan) begin
			id_q <= entry_id;
		end
		if (load_res) begin
			status_q <= res_status;
			occ_q    <= res_occ;
		end
		// drop stale fields on every new transfer; capture the matching head
		if (clr_rem) begin
			rem_id_q  <= '0;
			rem_pri_q <= '0;
			rem_pay_q <= '0;
		end else if (hit) begin
			rem_id_q  <= head_id;
			rem_pri_q <= head_pri;
			rem_pay_q <= head_pay;
		end
	end

	assign count            = count_q;
	assign tail             = CNT_W'(len_q - 1'b1);
	assign rsp_valid        = rsp_valid_q;
	assign status           = status_q;
	assign removed_id       = rem_id_q;
	assign removed_priority = rem_pri_q;
	assign removed_payload  = rem_pay_q;
	assign occupancy        = occ_q;

endmodule

>>> tb/tb_sorted_priority_queue_remove_by_id_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_priority_queue_remove_by_id_top.
// Uses spq_pkg for command and status codes; drives random inserts and removes
// with handshake idling and checks each response against an in-bench queue model.
module tb_sorted_priority_queue_remove_by_id_top;

	localparam int DEPTH        = spq_pkg::DEPTH_DEF;
	localparam int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF;
	localparam int ID_W         = spq_pkg::ID_W;
	localparam int PRI_W        = spq_pkg::PRI_W;
	localparam int OCC_W        = $clog2(DEPTH + 1);
	localparam int RANDOM_ITEMS = 1525;
	localparam int QUIET_TAIL   = 150;
	localparam int CYCLE_LIMIT  = 1000000;

	typedef struct {
		logic                    cmd;
		logic [ID_W-1:0]         id;
		logic [PRI_W-1:0]        pri;
		logic [PAYLOAD_BITS-1:0] pay;
	} queue_req_t;

	typedef struct {
		spq_pkg::status_t        st;
		logic [ID_W-1:0]         id;
		logic [PRI_W-1:0]        pri;
		logic [PAYLOAD_BITS-1:0] pay;
		logic [OCC_W-1:0]        occ;
	} queue_rsp_t;

	typedef struct {
		logic [ID_W-1:0]         id;
		logic [PRI_W-1:0]        pri;
		logic [PAYLOAD_BITS-1:0] pay;
	} slot_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    req_valid = 1'b0;
	logic                    req_stall;
	logic                    command = spq_pkg::CMD_INSERT;
	logic [ID_W-1:0]         entry_id = '0;
	logic [PRI_W-1:0]        entry_priority = '0;
	logic [PAYLOAD_BITS-1:0] entry_payload = '0;
	logic                    rsp_valid;
	logic                    rsp_stall = 1'b0;
	logic [1:0]              status;
	logic [ID_W-1:0]         removed_id;
	logic [PRI_W-1:0]        removed_priority;
	logic [PAYLOAD_BITS-1:0] removed_payload;
	logic [OCC_W-1:0]        occupancy;

	sorted_priority_queue_remove_by_id_top #(
		.DEPTH(DEPTH),
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.command(command),
		.entry_id(entry_id),
		.entry_priority(entry_priority),
		.entry_payload(entry_payload),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.removed_id(removed_id),
		.removed_priority(removed_priority),
		.removed_payload(removed_payload),
		.occupancy(occupancy)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	queue_req_t pending_requests[$];
	queue_rsp_t expected_responses[$];
	int         shadow_ids[$];

	slot_t      model_slots[DEPTH];
	int         model_count = 0;

	int         total_items = 0;
	int         n_accepted = 0;
	int         n_errors = 0;
	int         cycle_count = 0;
	int         send_gap = 0;
	int         recv_gap = 0;
	int         n_insert = 0, n_full = 0, n_remove = 0;
	int         n_rm_ok = 0, n_empty = 0, n_not_found = 0, peak_occ = 0;

	// Idling is allowed except in every fourth window of the cycle count and in the tail.
	function automatic bit idle_allowed();
		return (n_accepted < total_items - QUIET_TAIL) && (((cycle_count / 256) % 4) != 3);
	endfunction

	task automatic predict_queue_op(input queue_req_t r);
		queue_rsp_t e;
		int         pos;
		int         k;
		e.st  = spq_pkg::STAT_OK;
		e.id  = '0;
		e.pri = '0;
		e.pay = '0;
		if (r.cmd == spq_pkg::CMD_INSERT) begin
			n_insert++;
			if (model_count >= DEPTH) begin
				e.st = spq_pkg::STAT_FULL;
				n_full++;
			end else begin
				pos = 0;
				while (pos < model_count && model_slots[pos].pri >= r.pri)
					pos++;
				for (k = model_count; k > pos; k--)
					model_slots[k] = model_slots[k-1];
				model_slots[pos].id  = r.id;
				model_slots[pos].pri = r.pri;
				model_slots[pos].pay = r.pay;
				model_count++;
			end
		end else begin
			n_remove++;
			if (model_count == 0) begin
				e.st = spq_pkg::STAT_EMPTY;
				n_empty++;
			end else begin
				pos = 0;
				while (pos < model_count && model_slots[pos].id != r.id)
					pos++;
				if (pos >= model_count) begin
					e.st = spq_pkg::STAT_NOT_FOUND;
					n_not_found++;
				end else begin
					e.id  = model_slots[pos].id;
					e.pri = model_slots[pos].pri;
					e.pay = model_slots[pos].pay;
					for (k = pos; k + 1 < model_count; k++)
						model_slots[k] = model_slots[k+1];
					model_count--;
					n_rm_ok++;
				end
			end
		end
		if (model_count > peak_occ)
			peak_occ = model_count;
		e.occ = model_count[OCC_W-1:0];
		expected_responses.push_back(e);
	endtask

	// Queue a request and keep the multiset of stored ids in step with it.
	task automatic add_request(input logic cmd, input int id, input int pri, input int pay);
		queue_req_t r;
		int         i;
		r.cmd = cmd;
		r.id  = id[ID_W-1:0];
		r.pri = pri[PRI_W-1:0];
		r.pay = pay[PAYLOAD_BITS-1:0];
		pending_requests.push_back(r);
		if (cmd == spq_pkg::CMD_INSERT) begin
			if (shadow_ids.size() < DEPTH)
				shadow_ids.push_back(r.id);
		end else begin
			for (i = 0; i < shadow_ids.size(); i++) begin
				if (shadow_ids[i] == r.id) begin
					shadow_ids.delete(i);
					break;
				end
			end
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
			n_errors++;
		end
	endtask

	// Request driver: hold while stalled, otherwise advance or insert an idle burst.
	always @(posedge clk) begin
		queue_req_t r;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall) begin
				r.cmd = command;
				r.id  = entry_id;
				r.pri = entry_priority;
				r.pay = entry_payload;
				predict_queue_op(r);
				n_accepted++;
			end
			if (!(req_valid && req_stall)) begin
				if (send_gap > 0) begin
					req_valid <= 1'b0;
					send_gap  <= send_gap - 1;
				end else if (pending_requests.size() > 0) begin
					if (idle_allowed() && $urandom_range(0, 7) == 0) begin
						req_valid <= 1'b0;
						send_gap  <= $urandom_range(0, 5);
					end else begin
						r = pending_requests.pop_front();
						req_valid      <= 1'b1;
						command        <= r.cmd;
						entry_id       <= r.id;
						entry_priority <= r.pri;
						entry_payload  <= r.pay;
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor: compare each transfer with the oldest prediction.
	always @(posedge clk) begin
		queue_rsp_t e;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_responses.size() == 0) begin
					$display("%0t: unexpected response: status %0d occupancy %0d",
						$time, status, occupancy);
					n_errors++;
				end else begin
					e = expected_responses.pop_front();
					check_field("status", e.st, status);
					check_field("removed_id", e.id, removed_id);
					check_field("removed_priority", e.pri, removed_priority);
					check_field("removed_payload", e.pay, removed_payload);
					check_field("occupancy", e.occ, occupancy);
				end
			end
			if (recv_gap > 0) begin
				rsp_stall <= 1'b1;
				recv_gap  <= recv_gap - 1;
			end else if (idle_allowed() && $urandom_range(0, 9) == 0) begin
				rsp_stall <= 1'b1;
				recv_gap  <= $urandom_range(0, 5);
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("tb_sorted_priority_queue_remove_by_id_top: FAIL");
			$finish;
		end
	end

	initial begin
		bit filling;
		int i;
		int id;
		int pri;
		int sel;

		// Directed: empty remove, field extremes, ties, duplicate ids, absent id.
		add_request(spq_pkg::CMD_REMOVE, 8'h05, 0, 0);
		add_request(spq_pkg::CMD_INSERT, 8'h00, 8'h00, 16'h0000);
		add_request(spq_pkg::CMD_INSERT, 8'hff, 8'hff, 16'hffff);
		add_request(spq_pkg::CMD_INSERT, 8'h55, 8'h80, 16'ha5a5);
		add_request(spq_pkg::CMD_INSERT, 8'haa, 8'h80, 16'h5a5a);
		add_request(spq_pkg::CMD_INSERT, 8'h55, 8'h80, 16'h1234);
		add_request(spq_pkg::CMD_INSERT, 8'h07, 8'hff, 16'h0001);
		add_request(spq_pkg::CMD_REMOVE, 8'h55, 8'hff, 16'hffff);
		add_request(spq_pkg::CMD_REMOVE, 8'h99, 0, 0);
		add_request(spq_pkg::CMD_REMOVE, 8'h55, 0, 0);
		add_request(spq_pkg::CMD_REMOVE, 8'hff, 0, 0);
		add_request(spq_pkg::CMD_REMOVE, 8'h07, 0, 0);
		add_request(spq_pkg::CMD_REMOVE, 8'h00, 0, 0);
		add_request(spq_pkg::CMD_REMOVE, 8'haa, 0, 0);
		add_request(spq_pkg::CMD_REMOVE, 8'h00, 0, 0);
		add_request(spq_pkg::CMD_INSERT, 8'h99, 8'h00, 16'hffff);
		add_request(spq_pkg::CMD_REMOVE, 8'h99, 0, 0);

		// Random: alternate fill and drain phases so the queue runs full and empty.
		filling = 1'b1;
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (filling && shadow_ids.size() == DEPTH && $urandom_range(0, 3) == 0)
				filling = 1'b0;
			else if (!filling && shadow_ids.size() == 0 && $urandom_range(0, 3) == 0)
				filling = 1'b1;
			if ($urandom_range(0, 99) < (filling ? 85 : 15)) begin
				id  = $urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom_range(0, 255);
				sel = $urandom_range(0, 3);
				if (sel < 2)
					pri = $urandom_range(0, 7);
				else if (sel == 2)
					pri = $urandom_range(0, 255);
				else
					pri = $urandom_range(0, 1) ? 255 : 0;
				add_request(spq_pkg::CMD_INSERT, id, pri, $urandom_range(0, 65535));
			end else begin
				if (shadow_ids.size() > 0 && $urandom_range(0, 3) != 0)
					id = shadow_ids[$urandom_range(0, shadow_ids.size() - 1)];
				else
					id = $urandom_range(0, 255);
				add_request(spq_pkg::CMD_REMOVE, id, $urandom_range(0, 255),
					$urandom_range(0, 65535));
			end
		end
		total_items = pending_requests.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (!(n_accepted == total_items && expected_responses.size() == 0))
			@(posedge clk);
		// A remove can rotate the whole row; leave room for any stray response.
		repeat (3 * DEPTH) @(posedge clk);

		$display("covered %0d inserts (%0d full) and %0d removes (%0d ok, %0d empty, %0d absent)",
			n_insert, n_full, n_remove, n_rm_ok, n_empty, n_not_found);
		$display("peak occupancy %0d of %0d, %0d cycles", peak_occ, DEPTH, cycle_count);
		if (n_errors == 0)
			$display("tb_sorted_priority_queue_remove_by_id_top: PASS");
		else
			$display("tb_sorted_priority_queue_remove_by_id_top: FAIL");
		$finish;
	end

endmodule
